@@ src/priority_batch_reorder_queue_macros.svh @@
// Assertion macros shared by the priority batch reorder queue modules.
// A module that uses them must have a clock named clk and a reset named rst_n.
`ifndef PRIORITY_BATCH_REORDER_QUEUE_MACROS_SVH
`define PRIORITY_BATCH_REORDER_QUEUE_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define PBRQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define PBRQ_ASSERT_NEVER(label, cond, msg) \
    `PBRQ_ASSERT(label, !(cond), msg)

`endif

@@ src/pbrq_pkg.sv @@
// Package for the priority batch reorder queue: sizes, command and state types.
// Used by pbrq_front, pbrq_back and the top level; depends on nothing.
package pbrq_pkg;

    localparam int DEPTH    = 16;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int QD       = 2;
    localparam int QPTR_W   = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCNT_W   = $clog2(QD + 1);
    localparam int PRIO_W   = 16;
    localparam int SIZE_W   = 16;
    localparam int HANDLE_W = 16;
    localparam int LIMIT_W  = 20;

    localparam logic [LIMIT_W-1:0] LIMIT_MAX = {LIMIT_W{1'b1}};

    typedef enum logic
    {
        OP_INSERT,
        OP_FLUSH
    } op_t;

    typedef struct packed
    {
        op_t                        op;
        logic signed [PRIO_W-1:0]   prio;
        logic [SIZE_W-1:0]          size;
        logic [HANDLE_W-1:0]        handle;
    } cmd_t;

    typedef enum logic
    {
        ST_IDLE,
        ST_DRAIN
    } back_state_t;

endpackage

@@ src/pbrq_front.sv @@
// Front end of the priority batch reorder queue: accepts and classifies items
// and holds them in a short command queue. Depends on pbrq_pkg and the macros.
`include "priority_batch_reorder_queue_macros.svh"

module pbrq_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                req_type,
    input  logic signed [pbrq_pkg::PRIO_W-1:0]  priority_req,
    input  logic [pbrq_pkg::SIZE_W-1:0]         size,
    input  logic [pbrq_pkg::HANDLE_W-1:0]       packet_handle,
    output logic                                q_valid,
    output pbrq_pkg::cmd_t                      q_head,
    input  logic                                q_pop
);
    import pbrq_pkg::*;

    cmd_t              slot_reg [QD];
    cmd_t              cmd_in;
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;

    assign busy    = (count_reg == QCNT_W'(QD));
    assign push    = start && !busy;
    assign q_valid = (count_reg != '0);
    assign q_head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cmd_in = '0;
        if (req_type)
        begin
            cmd_in.op = OP_FLUSH;
        end
        else
        begin
            cmd_in.op     = OP_INSERT;
            cmd_in.prio   = priority_req;
            cmd_in.size   = size;
            cmd_in.handle = packet_handle;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    `PBRQ_ASSERT_NEVER(a_pop_when_empty, q_pop && (count_reg == '0), "queue popped while empty")
    `PBRQ_ASSERT(a_fill_tracks_push, (push && !q_pop) |=> (count_reg == $past(count_reg) + 1'b1), "queue fill count lost a push")

endmodule

@@ src/pbrq_back.sv @@
// Back end of the priority batch reorder queue: the sorted cell row, batch size
// accounting and batch draining. Depends on pbrq_pkg and the macros.
`include "priority_batch_reorder_queue_macros.svh"

module pbrq_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [pbrq_pkg::LIMIT_W-1:0]        batch_limit,
    input  logic                                q_valid,
    input  pbrq_pkg::cmd_t                      q_head,
    output logic                                q_pop,
    output logic                                result_valid,
    output logic [pbrq_pkg::HANDLE_W-1:0]       out_handle,
    output logic signed [pbrq_pkg::PRIO_W-1:0]  out_priority,
    output logic                                batch_last
);
    import pbrq_pkg::*;

    back_state_t              state_reg;
    back_state_t              state_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [LIMIT_W-1:0]       acc_reg;
    logic [LIMIT_W-1:0]       acc_next;
    logic                     valid_reg;
    logic                     valid_next;
    logic                     last_reg;
    logic                     last_next;
    logic [HANDLE_W-1:0]      handle_out_reg;
    logic [HANDLE_W-1:0]      handle_out_next;
    logic signed [PRIO_W-1:0] prio_out_reg;
    logic signed [PRIO_W-1:0] prio_out_next;

    logic signed [PRIO_W-1:0] prio_reg   [DEPTH];
    logic signed [PRIO_W-1:0] prio_next  [DEPTH];
    logic [HANDLE_W-1:0]      handle_reg [DEPTH];
    logic [HANDLE_W-1:0]      handle_next[DEPTH];

    logic signed [PRIO_W-1:0] key;
    logic [DEPTH-1:0]         stay;
    logic [LIMIT_W:0]         acc_sum;
    logic                     over_limit;
    logic                     store_full;
    logic                     must_emit;
    logic                     do_insert;
    logic                     do_shift;

    assign key        = q_head.prio;
    assign acc_sum    = {1'b0, acc_reg} + (LIMIT_W + 1)'(q_head.size);
    assign over_limit = (acc_sum > {1'b0, batch_limit});
    assign store_full = (count_reg == CNT_W'(DEPTH));
    assign must_emit  = (count_reg != '0) && (over_limit || store_full);

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            stay[i] = (CNT_W'(i) < count_reg) && !(key > prio_reg[i]);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        acc_next        = acc_reg;
        valid_next      = 1'b0;
        last_next       = 1'b0;
        handle_out_next = handle_out_reg;
        prio_out_next   = prio_out_reg;
        q_pop           = 1'b0;
        do_insert       = 1'b0;
        do_shift        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_head.op)
                        OP_INSERT:
                        begin
                            if (must_emit)
                            begin
                                state_next = ST_DRAIN;
                            end
                            else
                            begin
                                q_pop      = 1'b1;
                                do_insert  = 1'b1;
                                count_next = count_reg + 1'b1;
                                acc_next   = acc_sum[LIMIT_W] ? LIMIT_MAX
                                                              : acc_sum[LIMIT_W-1:0];
                            end
                        end
                        OP_FLUSH:
                        begin
                            q_pop = 1'b1;
                            if (count_reg != '0)
                            begin
                                state_next = ST_DRAIN;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_DRAIN:
            begin
                do_shift        = 1'b1;
                valid_next      = 1'b1;
                handle_out_next = handle_reg[0];
                prio_out_next   = prio_reg[0];
                count_next      = count_reg - 1'b1;
                if (count_reg == CNT_W'(1))
                begin
                    last_next  = 1'b1;
                    acc_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            prio_next[i]   = prio_reg[i];
            handle_next[i] = handle_reg[i];
        end
        if (do_shift)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                prio_next[i]   = prio_reg[i + 1];
                handle_next[i] = handle_reg[i + 1];
            end
        end
        else if (do_insert)
        begin
            if (!stay[0])
            begin
                prio_next[0]   = key;
                handle_next[0] = q_head.handle;
            end
            for (int i = 1; i < DEPTH; i++)
            begin
                if (!stay[i])
                begin
                    if (stay[i - 1])
                    begin
                        prio_next[i]   = key;
                        handle_next[i] = q_head.handle;
                    end
                    else
                    begin
                        prio_next[i]   = prio_reg[i - 1];
                        handle_next[i] = handle_reg[i - 1];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            acc_reg   <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        handle_out_reg <= handle_out_next;
        prio_out_reg   <= prio_out_next;
        for (int i = 0; i < DEPTH; i++)
        begin
            prio_reg[i]   <= prio_next[i];
            handle_reg[i] <= handle_next[i];
        end
    end

    assign result_valid = valid_reg;
    assign out_handle   = handle_out_reg;
    assign out_priority = prio_out_reg;
    assign batch_last   = last_reg;

    `PBRQ_ASSERT(a_result_from_drain, valid_reg |-> ($past(state_reg) == ST_DRAIN), "item emitted outside a drain")
    `PBRQ_ASSERT(a_drain_counts_down, (state_reg == ST_DRAIN) |=> (count_reg == $past(count_reg) - 1'b1), "drain did not remove one entry")
    `PBRQ_ASSERT_NEVER(a_count_in_range, count_reg > CNT_W'(DEPTH), "entry count beyond store depth")

endmodule

@@ src/priority_batch_reorder_queue.sv @@
// Top level of the priority batch reorder queue: batch limit register, front
// end and back end. Depends on pbrq_pkg, pbrq_front and pbrq_back.
//
// Packets are held sorted, highest priority first, and emitted as batches, one
// item per clock cycle on result_valid; the receiver cannot stall, so results
// must be taken as they appear. A two-entry command queue accepts items while
// busy is low. In the back end an insert that emits nothing goes straight
// into the cell row; an end-of-stream flush drains the stored packets, and an
// insert that would pass the batch limit or find the row full first drains the
// stored batch, the cell row draining at one packet per cycle. Results leave
// the back end through registers.
module priority_batch_reorder_queue
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pbrq_pkg::LIMIT_W-1:0]        cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic                                req_type,
    input  logic signed [pbrq_pkg::PRIO_W-1:0]  priority_req,
    input  logic [pbrq_pkg::SIZE_W-1:0]         size,
    input  logic [pbrq_pkg::HANDLE_W-1:0]       packet_handle,
    output logic                                result_valid,
    output logic [pbrq_pkg::HANDLE_W-1:0]       out_handle,
    output logic signed [pbrq_pkg::PRIO_W-1:0]  out_priority,
    output logic                                batch_last
);
    import pbrq_pkg::*;

    logic [LIMIT_W-1:0] limit_reg;
    logic [LIMIT_W-1:0] limit_next;
    logic               q_valid;
    cmd_t               q_head;
    logic               q_pop;

    assign limit_next = cfg_we ? cfg_data : limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_MAX;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    pbrq_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .priority_req  (priority_req),
        .size          (size),
        .packet_handle (packet_handle),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop)
    );

    pbrq_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .batch_limit  (limit_reg),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .out_handle   (out_handle),
        .out_priority (out_priority),
        .batch_last   (batch_last)
    );

endmodule
